// ----- rtl/jdg_pkg.sv -----
package jdg_pkg;

  // Field widths of the stream ports.
  localparam int JdWidth    = 23;
  localparam int YearWidth  = 15;
  localparam int MonthWidth = 4;
  localparam int DayWidth   = 5;

  // Pipeline stages, from the input register to the result register.
  localparam int NumStages    = 6;
  localparam int StageIn      = 0;
  localparam int StageCent    = 1;
  localparam int StageCentRem = 2;
  localparam int StageQuad    = 3;
  localparam int StageQuadRem = 4;
  localparam int StageOut     = 5;

  // Calendar constants.
  localparam int unsigned JdOffset = 32044;
  localparam int unsigned QuadCent = 146097;
  localparam int unsigned QuadYear = 1461;
  localparam int unsigned YearsPerCent = 100;

  // Internal widths, sized to the largest value each one can carry.
  localparam int AWidth     = 24;  // day number plus offset
  localparam int CentNumWidth = AWidth + 2;  // 4*a + 3
  localparam int BWidth     = 8;   // centuries
  localparam int CWidth     = 16;  // days within a century
  localparam int QuadNumWidth = 18;  // 4*c + 3
  localparam int DWidth     = 7;   // years within a century
  localparam int EWidth     = 9;   // day of the year counted from March
  localparam int YBaseWidth = 15;  // 100*b + d
  localparam int YearCalcWidth = 16;

  // Division by a constant as a multiply by a rounded-up reciprocal. The shift is the
  // dividend width plus the divisor's bit length, which keeps the quotient exact.
  localparam int CentShift       = CentNumWidth + 18;
  localparam int CentRecipWidth  = 27;
  localparam logic [CentRecipWidth-1:0] CentRecip = CentRecipWidth'(
      ((64'd1 << CentShift) + 64'(QuadCent) - 64'd1) / 64'(QuadCent));
  localparam int CentProdWidth   = CentNumWidth + CentRecipWidth;

  localparam int QuadShift       = QuadNumWidth + 11;
  localparam int QuadRecipWidth  = 19;
  localparam logic [QuadRecipWidth-1:0] QuadRecip = QuadRecipWidth'(
      ((64'd1 << QuadShift) + 64'(QuadYear) - 64'd1) / 64'(QuadYear));
  localparam int QuadProdWidth   = QuadNumWidth + QuadRecipWidth;

  // First day of each month, counted from March 1 as day zero.
  localparam int MonthsPerYear = 12;
  localparam logic [MonthsPerYear-1:0][EWidth-1:0] MonthStart = {
    9'd337, 9'd306, 9'd275, 9'd245, 9'd214, 9'd184,
    9'd153, 9'd122, 9'd92,  9'd61,  9'd31,  9'd0
  };

  // Month index of January; from here on the year count moves up by one.
  localparam logic [MonthWidth-1:0] WrapMonth   = 4'd10;
  localparam logic [MonthWidth-1:0] WrapBack    = 4'd9;
  localparam logic [MonthWidth-1:0] MarchNumber = 4'd3;

  localparam logic signed [YearCalcWidth-1:0] YearRebase = 16'sd4800;
  localparam logic signed [YearCalcWidth-1:0] YearMax    = 16'sd16383;

  // Pipeline control travelling from the controller to the datapath.
  typedef struct packed {
    logic [NumStages-1:0] load;
    logic [NumStages-1:0] valid;
  } pipe_ctrl_t;

endpackage

// ----- rtl/jdg_pipe_ctrl.sv -----
module jdg_pipe_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output jdg_pkg::pipe_ctrl_t ctrl_o
);
  import jdg_pkg::*;

  logic [NumStages-1:0] valid_q, valid_d;
  logic [NumStages:0]   ready;

  // A stage may load when it is empty or when its contents move on in this cycle.
  always_comb begin
    ready[NumStages] = ~out_stall_i;
    for (int k = NumStages - 1; k >= 0; k--) begin
      ready[k] = ~valid_q[k] | ready[k+1];
    end
  end

  // Valid bits follow the data one stage per load.
  always_comb begin
    valid_d[StageIn] = ready[StageIn] ? in_valid_i : valid_q[StageIn];
    for (int k = 1; k < NumStages; k++) begin
      valid_d[k] = ready[k] ? valid_q[k-1] : valid_q[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  assign ctrl_o.load  = ready[NumStages-1:0];
  assign ctrl_o.valid = valid_q;
  assign in_stall_o   = ~ready[StageIn];
  assign out_valid_o  = valid_q[StageOut];

endmodule

// ----- rtl/jdg_cent_split.sv -----
module jdg_cent_split (
  input  logic                         clk_i,
  input  jdg_pkg::pipe_ctrl_t          ctrl_i,
  input  logic [jdg_pkg::JdWidth-1:0]  julian_day_i,
  output logic [jdg_pkg::BWidth-1:0]   cycles_o,
  output logic [jdg_pkg::CWidth-1:0]   days_o
);
  import jdg_pkg::*;

  logic [JdWidth-1:0]       jd_q;
  logic [AWidth-1:0]        a_d, a_q;
  logic [CentNumWidth-1:0]  cent_num;
  logic [CentProdWidth-1:0] cent_prod;
  logic [BWidth-1:0]        b_d, b_q, b2_q;
  logic [CentNumWidth-1:0]  cent_base;
  logic [CWidth-1:0]        c_d, c_q;

  // Offset the day number and count whole centuries.
  always_comb begin
    a_d       = AWidth'(jd_q) + AWidth'(JdOffset);
    cent_num  = {a_d, 2'b11};
    cent_prod = cent_num * CentRecip;
    b_d       = cent_prod[CentShift +: BWidth];
  end

  // Days left over within the current century.
  always_comb begin
    cent_base = CentNumWidth'(b_q) * CentNumWidth'(QuadCent);
    c_d       = CWidth'(a_q - cent_base[CentNumWidth-1:2]);
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load[StageIn]) begin
      jd_q <= julian_day_i;
    end
    if (ctrl_i.load[StageCent]) begin
      a_q <= a_d;
      b_q <= b_d;
    end
    if (ctrl_i.load[StageCentRem]) begin
      b2_q <= b_q;
      c_q  <= c_d;
    end
  end

  assign cycles_o = b2_q;
  assign days_o   = c_q;

endmodule

// ----- rtl/jdg_quad_split.sv -----
module jdg_quad_split (
  input  logic                            clk_i,
  input  jdg_pkg::pipe_ctrl_t             ctrl_i,
  input  logic [jdg_pkg::BWidth-1:0]      cycles_i,
  input  logic [jdg_pkg::CWidth-1:0]      days_i,
  output logic [jdg_pkg::YBaseWidth-1:0]  year_base_o,
  output logic [jdg_pkg::EWidth-1:0]      year_day_o
);
  import jdg_pkg::*;

  logic [BWidth-1:0]        b_q;
  logic [CWidth-1:0]        c_q;
  logic [QuadNumWidth-1:0]  quad_num;
  logic [QuadProdWidth-1:0] quad_prod;
  logic [DWidth-1:0]        d_d, d_q;
  logic [QuadNumWidth-1:0]  quad_base;
  logic [EWidth-1:0]        e_d, e_q;
  logic [YBaseWidth-1:0]    ybase_d, ybase_q;

  // Count whole years within the century.
  always_comb begin
    quad_num  = {days_i, 2'b11};
    quad_prod = quad_num * QuadRecip;
    d_d       = quad_prod[QuadShift +: DWidth];
  end

  // Day of the year counted from March, and the year before the re-base.
  always_comb begin
    quad_base = QuadNumWidth'(d_q) * QuadNumWidth'(QuadYear);
    e_d       = EWidth'(c_q - quad_base[QuadNumWidth-1:2]);
    ybase_d   = YBaseWidth'(b_q) * YBaseWidth'(YearsPerCent) + YBaseWidth'(d_q);
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load[StageQuad]) begin
      b_q <= cycles_i;
      c_q <= days_i;
      d_q <= d_d;
    end
    if (ctrl_i.load[StageQuadRem]) begin
      e_q     <= e_d;
      ybase_q <= ybase_d;
    end
  end

  assign year_base_o = ybase_q;
  assign year_day_o  = e_q;

endmodule

// ----- rtl/jdg_date_fmt.sv -----
module jdg_date_fmt (
  input  logic                                clk_i,
  input  jdg_pkg::pipe_ctrl_t                 ctrl_i,
  input  logic                                allow_year_zero_i,
  input  logic [jdg_pkg::YBaseWidth-1:0]      year_base_i,
  input  logic [jdg_pkg::EWidth-1:0]          year_day_i,
  output logic signed [jdg_pkg::YearWidth-1:0] year_o,
  output logic [jdg_pkg::MonthWidth-1:0]      month_o,
  output logic [jdg_pkg::DayWidth-1:0]        day_of_month_o
);
  import jdg_pkg::*;

  logic [MonthWidth-1:0]           month_idx;
  logic                            wrap;
  logic [EWidth-1:0]               day_full;
  logic signed [YearCalcWidth-1:0] year_full;
  logic signed [YearWidth-1:0]     year_d, year_q;
  logic [MonthWidth-1:0]           month_d, month_q;
  logic [DayWidth-1:0]             day_d, day_q;

  // Month index from March: the last month whose first day is not past the day.
  always_comb begin
    month_idx = '0;
    for (int k = 1; k < MonthsPerYear; k++) begin
      if (year_day_i >= MonthStart[k]) begin
        month_idx = MonthWidth'(k);
      end
    end
  end

  // Calendar month and day; January and February belong to the next year.
  always_comb begin
    wrap     = (month_idx >= WrapMonth);
    month_d  = wrap ? (month_idx - WrapBack) : (month_idx + MarchNumber);
    day_full = year_day_i - MonthStart[month_idx] + EWidth'(1);
    day_d    = day_full[DayWidth-1:0];
  end

  // Re-base the year, skip year zero when asked, and clip at the field's top.
  always_comb begin
    year_full = signed'({1'b0, year_base_i + YBaseWidth'(wrap)}) - YearRebase;
    if (!allow_year_zero_i && (year_full < 16'sd1)) begin
      year_full = year_full - 16'sd1;
    end
    if (year_full > YearMax) begin
      year_full = YearMax;
    end
    year_d = year_full[YearWidth-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load[StageOut]) begin
      year_q  <= year_d;
      month_q <= month_d;
      day_q   <= day_d;
    end
  end

  assign year_o         = year_q;
  assign month_o        = month_q;
  assign day_of_month_o = day_q;

endmodule

// ----- rtl/julian_day_to_gregorian_date_top.sv -----
// Julian day number to proleptic Gregorian date converter.
//
// Input channel: julian_day_i with in_valid_i / in_stall_o. A beat is taken at a
// rising edge where in_valid_i is high and in_stall_o is low.
// Output channel: year_o (two's complement, negative is BC), month_o and
// day_of_month_o with out_valid_o / out_stall_i. Every input beat gives one output beat.
// Configuration: cfg_we_i writes cfg_wdata_i into allow_year_zero; 1 keeps year zero,
// 0 numbers the years before 1 AD as -1, -2 and so on. Write it only while idle.
//
// Pipeline: six register stages. Throughput is one beat per cycle while out_stall_i
// is low, set by the six-stage pipeline whose two constant-reciprocal multipliers
// each sit in a stage of their own.
// When the receiver stalls, the result register holds and the stages behind it keep
// filling their empty slots; in_stall_o rises only once every stage is occupied.
// Reset clears all valid bits and sets allow_year_zero to 0; no clearing pass runs.
module julian_day_to_gregorian_date_top (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic                                  cfg_wdata_i,
  input  logic [jdg_pkg::JdWidth-1:0]           julian_day_i,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  output logic signed [jdg_pkg::YearWidth-1:0]  year_o,
  output logic [jdg_pkg::MonthWidth-1:0]        month_o,
  output logic [jdg_pkg::DayWidth-1:0]          day_of_month_o,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i
);
  import jdg_pkg::*;

  pipe_ctrl_t            pipe_ctrl;
  logic                  allow_year_zero_q;
  logic [BWidth-1:0]     cycles;
  logic [CWidth-1:0]     days;
  logic [YBaseWidth-1:0] year_base;
  logic [EWidth-1:0]     year_day;

  // Configuration register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      allow_year_zero_q <= 1'b0;
    end else if (cfg_we_i) begin
      allow_year_zero_q <= cfg_wdata_i;
    end
  end

  jdg_pipe_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .ctrl_o      (pipe_ctrl)
  );

  jdg_cent_split u_cent (
    .clk_i        (clk_i),
    .ctrl_i       (pipe_ctrl),
    .julian_day_i (julian_day_i),
    .cycles_o     (cycles),
    .days_o       (days)
  );

  jdg_quad_split u_quad (
    .clk_i       (clk_i),
    .ctrl_i      (pipe_ctrl),
    .cycles_i    (cycles),
    .days_i      (days),
    .year_base_o (year_base),
    .year_day_o  (year_day)
  );

  jdg_date_fmt u_fmt (
    .clk_i             (clk_i),
    .ctrl_i            (pipe_ctrl),
    .allow_year_zero_i (allow_year_zero_q),
    .year_base_i       (year_base),
    .year_day_i        (year_day),
    .year_o            (year_o),
    .month_o           (month_o),
    .day_of_month_o    (day_of_month_o)
  );

  // The input side stalls only when the whole pipeline is full.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
      in_stall_o |-> (&pipe_ctrl.valid))
    else $error("input stalled while a pipeline stage was empty");

  // Month and day come out of the month table in range.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
      out_valid_o |-> (month_o >= 4'd1) && (month_o <= 4'd12) && (day_of_month_o != 5'd0))
    else $error("month or day out of range");

  // Without year zero, no result carries year zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
      (out_valid_o && !allow_year_zero_q) |-> (year_o != 15'sd0))
    else $error("year zero produced while year zero is skipped");

  // An accepted beat with no stall on the way shows up once it has passed every stage.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
      (in_valid_i && !in_stall_o) ##1 !out_stall_i ##1 !out_stall_i ##1 !out_stall_i
        ##1 !out_stall_i ##1 !out_stall_i |=> out_valid_o)
    else $error("result missing after an unstalled pass");

endmodule
